// File: rtl/h2r_pkg.sv
package h2r_pkg;

  // Output duty width and full-scale code
  localparam int DutyBits = 13;
  localparam int MaxDuty  = (1 << DutyBits) - 1;

  localparam int HueW = 16;
  localparam int CfgW = 13;

  // Q1.12 unity and register reset values
  localparam int OneQ12 = 4096;
  localparam int SatRst = 4096;
  localparam int BriRst = 3277;

  // Hue reduction: hue + 32768 + HueBias is a positive multiple-of-turn offset
  localparam int HueBias    = 1792;
  localparam int SectorSpan = 960;   // 60 degrees in 1/16 degree units
  localparam int SpanUnits  = 15;    // SectorSpan / 64
  localparam int Sectors    = 6;
  localparam int Div15Mul   = 2185;  // floor(u / 15) = (u * 2185) >> 15, u < 2048
  localparam int Div15Shift = 15;
  localparam int Div6Mul    = 171;   // floor(q / 6) = (q * 171) >> 10, q < 128
  localparam int Div6Shift  = 10;

  localparam int C24W  = 25;
  localparam int TermW = 34;

  // Duty scaling: term * MaxDuty / (2^30 * 15)
  localparam int ScaleShift = 30;
  localparam int ScaleProdW = TermW + DutyBits;
  localparam int WideW      = DutyBits + 4;
  localparam int RecipShift = DutyBits + 8;
  localparam int RecipW     = DutyBits + 5;
  localparam int RecipMul   = ((1 << RecipShift) + SpanUnits - 1) / SpanUnits;
  localparam int RecipProdW = WideW + RecipW;

  // Derived register reset values
  localparam longint C24Rst   = longint'(SatRst) * longint'(BriRst);
  localparam longint CtermRst = C24Rst * longint'(SectorSpan);

  typedef logic signed [HueW-1:0] hue_t;
  typedef logic [CfgW-1:0]        cfg_t;
  typedef logic [DutyBits-1:0]    duty_t;
  typedef logic [C24W-1:0]        c24_t;
  typedef logic [TermW-1:0]       term_t;

  typedef enum logic [0:0] {
    CfgSaturation = 1'b0,
    CfgBrightness = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } sector_e;

  typedef struct packed {
    c24_t  c24;
    term_t cterm;
    term_t mterm;
  } cfg_terms_t;

endpackage

// File: rtl/h2r_cfg.sv
module h2r_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  h2r_pkg::cfg_idx_e   cfg_idx_i,
  input  h2r_pkg::cfg_t       cfg_wdata_i,
  output h2r_pkg::cfg_terms_t terms_o
);
  import h2r_pkg::*;

  cfg_t  sat_q, bri_q;
  cfg_t  sat_c, bri_c;
  c24_t  c24_q, m24_q;
  term_t cterm_q, mterm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= cfg_t'(SatRst);
      bri_q <= cfg_t'(BriRst);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSaturation: sat_q <= cfg_wdata_i;
        CfgBrightness: bri_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp above unity
  assign sat_c = (sat_q > cfg_t'(OneQ12)) ? cfg_t'(OneQ12) : sat_q;
  assign bri_c = (bri_q > cfg_t'(OneQ12)) ? cfg_t'(OneQ12) : bri_q;

  // Chroma and offset in Q1.24, then scaled by the sector span
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c24_q   <= c24_t'(C24Rst);
      m24_q   <= '0;
      cterm_q <= term_t'(CtermRst);
      mterm_q <= '0;
    end else begin
      c24_q   <= c24_t'(C24W'(bri_c) * C24W'(sat_c));
      m24_q   <= c24_t'(C24W'(bri_c) * C24W'(cfg_t'(OneQ12) - sat_c));
      cterm_q <= term_t'(TermW'(c24_q) * TermW'(SectorSpan));
      mterm_q <= term_t'(TermW'(m24_q) * TermW'(SectorSpan));
    end
  end

  assign terms_o = '{c24: c24_q, cterm: cterm_q, mterm: mterm_q};

endmodule

// File: rtl/hsv_to_rgb_duty.sv
// HSV to RGB duty converter for LED PWM.
// Input channel: hue_i (signed, 1/16 degree, any turn) with in_valid_i/in_ready_o.
// Output channel: red/green/blue_duty_o with out_valid_o/out_ready_i; one beat out
// for every beat in, in order.
// Saturation (index 0) and brightness (index 1) are Q1.12 registers written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i; values above 4096 act as 4096. Write them only
// while the pipeline is empty.
// Throughput: one beat per cycle while out_ready_i is high; every stage is a
// register with its own valid bit.
// Stages: hue bias and divide by 15, sector and remainder, secondary product,
// channel select plus offset, multiply by full scale, divide by 15.
// Reset clears all valid bits and loads the register defaults (saturation 1.0,
// brightness 0.8); the block accepts beats on the first edge after reset.
// When the receiver stalls, a stage holds only while the stage after it is full,
// so bubbles close up and input is still taken until every stage is occupied.
module hsv_to_rgb_duty (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  h2r_pkg::cfg_idx_e cfg_idx_i,
  input  h2r_pkg::cfg_t     cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  h2r_pkg::hue_t     hue_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output h2r_pkg::duty_t    red_duty_o,
  output h2r_pkg::duty_t    green_duty_o,
  output h2r_pkg::duty_t    blue_duty_o
);
  import h2r_pkg::*;

  localparam int NumStages = 6;
  localparam int NumChan   = 3;

  cfg_terms_t terms;

  h2r_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .terms_o     (terms)
  );

  // Valid bits and per-stage ready
  logic [NumStages:0]   vld;
  logic [NumStages:1]   vld_q, vld_d;
  logic [NumStages+1:1] rdy;
  logic [NumStages:1]   load;

  assign vld[0]                 = in_valid_i;
  assign vld[NumStages:1]       = vld_q;

  // Walk from the output back so each stage sees the ready of the one after it
  always_comb begin
    rdy[NumStages+1] = out_ready_i;
    for (int k = NumStages; k >= 1; k--) begin
      rdy[k]   = !vld_q[k] || rdy[k+1];
      load[k]  = rdy[k] && vld[k-1];
      vld_d[k] = rdy[k] ? vld[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[1];
  assign out_valid_o = vld_q[NumStages];

  // Stage 1: bias hue positive, split off low six bits, divide the rest by 15
  logic [16:0] biased;
  logic [21:0] div15_prod;
  logic [6:0]  quo_q;
  logic [10:0] unit_q;
  logic [5:0]  lo_q;

  assign biased     = 17'({~hue_i[HueW-1], hue_i[HueW-2:0]}) + 17'(HueBias);
  assign div15_prod = 22'(biased[16:6]) * 22'(Div15Mul);

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      quo_q  <= div15_prod[Div15Shift +: 7];
      unit_q <= biased[16:6];
      lo_q   <= biased[5:0];
    end
  end

  // Stage 2: sector = quotient mod 6, remainder within the sector
  logic [10:0] r15_full;
  logic [13:0] div6_prod;
  logic [3:0]  div6_quo;
  logic [6:0]  sec_full;
  logic [2:0]  sector_q;
  logic [9:0]  rem_q;

  assign r15_full  = unit_q - 11'(quo_q) * 11'(SpanUnits);
  assign div6_prod = 14'(quo_q) * 14'(Div6Mul);
  assign div6_quo  = div6_prod[Div6Shift +: 4];
  assign sec_full  = quo_q - 7'(div6_quo) * 7'(Sectors);

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      sector_q <= sec_full[2:0];
      rem_q    <= {r15_full[3:0], lo_q};
    end
  end

  // Stage 3: secondary term, rising in even sectors and falling in odd ones
  logic [9:0]      kx;
  logic [C24W+9:0] xprod;
  term_t           xterm_q;
  logic [2:0]      sec3_q;

  assign kx    = sector_q[0] ? (10'(SectorSpan) - rem_q) : rem_q;
  assign xprod = (C24W+10)'(terms.c24) * (C24W+10)'(kx);

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      xterm_q <= xprod[TermW-1:0];
      sec3_q  <= sector_q;
    end
  end

  // Stage 4: route chroma / secondary / zero to each channel, add offset
  term_t [NumChan-1:0] pick;
  term_t [NumChan-1:0] sum_q;

  always_comb begin
    case (sector_e'(sec3_q))
      SecRed:     pick = {term_t'(0), xterm_q, terms.cterm};
      SecYellow:  pick = {term_t'(0), terms.cterm, xterm_q};
      SecGreen:   pick = {xterm_q, terms.cterm, term_t'(0)};
      SecCyan:    pick = {terms.cterm, xterm_q, term_t'(0)};
      SecBlue:    pick = {terms.cterm, term_t'(0), xterm_q};
      default:    pick = {xterm_q, term_t'(0), terms.cterm};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      for (int ch = 0; ch < NumChan; ch++) begin
        sum_q[ch] <= pick[ch] + terms.mterm;
      end
    end
  end

  // Stage 5: multiply by full scale, drop 2^30 of the denominator
  logic [NumChan-1:0][ScaleProdW-1:0] scaled;
  logic [NumChan-1:0][WideW-1:0]      wide_q;

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      scaled[ch] = ScaleProdW'(sum_q[ch]) * ScaleProdW'(MaxDuty);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      for (int ch = 0; ch < NumChan; ch++) begin
        wide_q[ch] <= scaled[ch][ScaleShift +: WideW];
      end
    end
  end

  // Stage 6: divide by 15 through a reciprocal, exact over the whole range
  logic [NumChan-1:0][RecipProdW-1:0] recip;
  duty_t [NumChan-1:0]                duty_q;

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      recip[ch] = RecipProdW'(wide_q[ch]) * RecipProdW'(RecipMul);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[6]) begin
      for (int ch = 0; ch < NumChan; ch++) begin
        duty_q[ch] <= recip[ch][RecipShift +: DutyBits];
      end
    end
  end

  assign red_duty_o   = duty_q[0];
  assign green_duty_o = duty_q[1];
  assign blue_duty_o  = duty_q[2];

endmodule

// File: rtl/h2r_chk.sv
module h2r_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input h2r_pkg::duty_t red_duty_o,
  input h2r_pkg::duty_t green_duty_o,
  input h2r_pkg::duty_t blue_duty_o
);

  // Reset empties the pipeline by the next edge
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

  // A ready receiver lets every stage advance, so input is open
  a_ready_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while receiver ready");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped during stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(red_duty_o) && $stable(green_duty_o) && $stable(blue_duty_o))
    else $error("output beat changed during stall");

endmodule

bind hsv_to_rgb_duty h2r_chk u_h2r_chk (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import h2r_pkg::*;

  // One full turn of hue in 1/16 degree units
  localparam int HueTurn = 6 * SectorSpan;
  // Input beat to out_valid_o; drain_pipe adds slack on top for the settle pause
  localparam int PipeLatency = 6;
  localparam int RandPhases = 7;
  localparam int BeatsPerPhase = 250;
  localparam int ReportLimit = 10;

  typedef struct packed {
    duty_t red;
    duty_t green;
    duty_t blue;
  } rgb_t;

  // Directed row: hue plus the register setting it runs under. Rows with
  // known set carry their expected duties; the rest go through hsv_duty.
  typedef struct packed {
    hue_t  hue;
    cfg_t  sat;
    cfg_t  bri;
    logic  known;
    duty_t red;
    duty_t green;
    duty_t blue;
  } dir_row_t;

  localparam int DirRows = 24;
  localparam dir_row_t DirTable [DirRows] = '{
    // reset setting: saturation 1.0, brightness 0.8
    '{16'sd0,     13'd4096, 13'd3277, 1'b1, 13'd6553, 13'd0,    13'd0},
    '{16'sd960,   13'd4096, 13'd3277, 1'b0, 13'd0,    13'd0,    13'd0},
    // full saturation and brightness: primaries and secondaries at boundaries, hues next to a boundary and hue extremes
    '{16'sd0,     13'd4096, 13'd4096, 1'b1, 13'd8191, 13'd0,    13'd0},
    '{16'sd960,   13'd4096, 13'd4096, 1'b1, 13'd8191, 13'd8191, 13'd0},
    '{16'sd1920,  13'd4096, 13'd4096, 1'b1, 13'd0,    13'd8191, 13'd0},
    '{16'sd2880,  13'd4096, 13'd4096, 1'b1, 13'd0,    13'd8191, 13'd8191},
    '{16'sd3840,  13'd4096, 13'd4096, 1'b1, 13'd0,    13'd0,    13'd8191},
    '{16'sd4800,  13'd4096, 13'd4096, 1'b1, 13'd8191, 13'd0,    13'd8191},
    '{16'sd5760,  13'd4096, 13'd4096, 1'b1, 13'd8191, 13'd0,    13'd0},
    '{-16'sd960,  13'd4096, 13'd4096, 1'b1, 13'd8191, 13'd0,    13'd8191},
    '{16'sd959,   13'd4096, 13'd4096, 1'b0, 13'd0,    13'd0,    13'd0},
    '{16'sd961,   13'd4096, 13'd4096, 1'b0, 13'd0,    13'd0,    13'd0},
    '{16'sd32767, 13'd4096, 13'd4096, 1'b0, 13'd0,    13'd0,    13'd0},
    '{-16'sd32768, 13'd4096, 13'd4096, 1'b0, 13'd0,   13'd0,    13'd0},
    '{-16'sd1,    13'd4096, 13'd4096, 1'b0, 13'd0,    13'd0,    13'd0},
    // both registers above 1.0 clamp to 1.0
    '{16'sd0,     13'd8191, 13'd8191, 1'b1, 13'd8191, 13'd0,    13'd0},
    '{16'sd2880,  13'd8191, 13'd8191, 1'b1, 13'd0,    13'd8191, 13'd8191},
    // zero saturation: white at full brightness, any hue
    '{16'sd1234,  13'd0,    13'd4096, 1'b1, 13'd8191, 13'd8191, 13'd8191},
    '{-16'sd32768, 13'd0,   13'd4096, 1'b1, 13'd8191, 13'd8191, 13'd8191},
    // zero brightness: black, any hue
    '{16'sd4800,  13'd4096, 13'd0,    1'b1, 13'd0,    13'd0,    13'd0},
    '{16'sd32767, 13'd4096, 13'd0,    1'b1, 13'd0,    13'd0,    13'd0},
    // half saturation, brightness just above 1.0
    '{16'sd480,   13'd2048, 13'd4097, 1'b0, 13'd0,    13'd0,    13'd0},
    '{16'sd5759,  13'd2048, 13'd4097, 1'b0, 13'd0,    13'd0,    13'd0},
    // smallest nonzero setting
    '{16'sd3000,  13'd1,    13'd1,    1'b0, 13'd0,    13'd0,    13'd0}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  cfg_idx_e cfg_idx_i;
  cfg_t     cfg_wdata_i;
  logic     in_valid_i;
  logic     in_ready_o;
  hue_t     hue_i;
  logic     out_valid_o;
  logic     out_ready_i;
  duty_t    red_duty_o;
  duty_t    green_duty_o;
  duty_t    blue_duty_o;

  hsv_to_rgb_duty dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hue_i        (hue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_duty_o   (red_duty_o),
    .green_duty_o (green_duty_o),
    .blue_duty_o  (blue_duty_o)
  );

  // Shadow of the two registers as the block holds them
  cfg_t sat_reg = cfg_t'(SatRst);
  cfg_t bri_reg = cfg_t'(BriRst);

  // Duties still owed by the block, oldest first
  rgb_t expected_rgb [$];
  rgb_t head_rgb;

  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned settings;
  int unsigned fail_cnt;
  int unsigned stall_left;
  bit          in_steady;
  bit          out_steady;

  always #10 clk_i = ~clk_i;

  // Scale a channel term (units of 2^24 * 960) to the duty range; keep the
  // low DutyBits bits, as the hardware does.
  function automatic duty_t to_duty(input longint unsigned term);
    longint unsigned full;
    full = (64'd1 << 24) * SectorSpan;
    return duty_t'((term * MaxDuty) / full);
  endfunction

  // Expected duties for one hue under the given register setting
  function automatic rgb_t hsv_duty(input hue_t hue, input cfg_t sat, input cfg_t bri);
    int              deg;
    int unsigned     sector;
    int unsigned     rem;
    longint unsigned s;
    longint unsigned v;
    longint unsigned c24;
    longint unsigned cterm;
    longint unsigned xterm;
    longint unsigned mterm;
    longint unsigned r;
    longint unsigned g;
    longint unsigned b;
    rgb_t            res;
    // clamp both registers to 1.0
    s = (sat > OneQ12) ? OneQ12 : sat;
    v = (bri > OneQ12) ? OneQ12 : bri;
    // reduce modulo one turn, wrapping negative hues upward
    deg = int'(hue) % HueTurn;
    if (deg < 0) begin
      deg += HueTurn;
    end
    sector = deg / SectorSpan;
    rem    = deg % SectorSpan;
    c24    = v * s;
    cterm  = c24 * SectorSpan;
    // rising ramp in even sectors, falling ramp in odd ones
    if (sector[0] == 1'b0) begin
      xterm = c24 * rem;
    end else begin
      xterm = c24 * (SectorSpan - rem);
    end
    mterm = (v * OneQ12 - c24) * SectorSpan;
    case (sector_e'(sector[2:0]))
      SecRed: begin
        r = cterm; g = xterm; b = 0;
      end
      SecYellow: begin
        r = xterm; g = cterm; b = 0;
      end
      SecGreen: begin
        r = 0; g = cterm; b = xterm;
      end
      SecCyan: begin
        r = 0; g = xterm; b = cterm;
      end
      SecBlue: begin
        r = xterm; g = 0; b = cterm;
      end
      default: begin
        r = cterm; g = 0; b = xterm;
      end
    endcase
    res.red   = to_duty(r + mterm);
    res.green = to_duty(g + mterm);
    res.blue  = to_duty(b + mterm);
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned roll;
    if (steady) begin
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(3, 1);
    end else if (roll < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  // Hue stimulus: full 16-bit noise, hues near sector boundaries in any turn,
  // and plain hues within one turn
  function automatic hue_t pick_hue();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 4) begin
      return hue_t'($urandom);
    end else if (roll < 7) begin
      return hue_t'(int'($urandom_range(5)) * SectorSpan +
                    (int'($urandom_range(9)) - 5) * HueTurn +
                    int'($urandom_range(4)) - 2);
    end
    return hue_t'($urandom_range(HueTurn - 1));
  endfunction

  task automatic report_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= ReportLimit) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Present one hue beat, hold it until taken, then record what it owes.
  // Valid stays high across back-to-back beats; drop it only for a gap.
  task automatic send_hue(input hue_t hue, input rgb_t want, input int unsigned gap);
    in_valid_i <= 1'b1;
    hue_i      <= hue;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rgb.push_back(want);
    beats_in++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every owed beat is out, then let the pipe settle
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges; only called with the pipe empty
  task automatic set_levels(input cfg_t sat, input cfg_t bri);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgSaturation;
    cfg_wdata_i <= sat;
    @(posedge clk_i);
    cfg_idx_i   <= CfgBrightness;
    cfg_wdata_i <= bri;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sat_reg = sat;
    bri_reg = bri;
    settings++;
  endtask

  // Receiver: accept by default, stall now and then for a random stretch.
  // Output-steady phases start no new stalls.
  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!out_steady && $urandom_range(99) < 20) begin
          stall_left = pick_gap(1'b0);
        end
      end
    end
  end

  // Result checker: every output beat must match the oldest owed duties
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (expected_rgb.size() == 0) begin
        report_fail($sformatf("unexpected beat r=%0d g=%0d b=%0d",
                              red_duty_o, green_duty_o, blue_duty_o));
      end else begin
        head_rgb = expected_rgb.pop_front();
        if (red_duty_o !== head_rgb.red || green_duty_o !== head_rgb.green ||
            blue_duty_o !== head_rgb.blue) begin
          report_fail($sformatf("duty mismatch: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                head_rgb.red, head_rgb.green, head_rgb.blue,
                                red_duty_o, green_duty_o, blue_duty_o));
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #15_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rgb_t  want;
    cfg_t  sat;
    cfg_t  bri;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgSaturation;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    hue_i       = '0;
    in_steady   = 1'b0;
    out_steady  = 1'b0;
    beats_in    = 0;
    beats_out   = 0;
    settings    = 0;
    fail_cnt    = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: reprogram only when the row's setting differs, and only
    // once the pipe has emptied
    for (int i = 0; i < DirRows; i++) begin
      if (DirTable[i].sat != sat_reg || DirTable[i].bri != bri_reg) begin
        drain_pipe();
        set_levels(DirTable[i].sat, DirTable[i].bri);
      end
      if (DirTable[i].known) begin
        want = '{DirTable[i].red, DirTable[i].green, DirTable[i].blue};
      end else begin
        want = hsv_duty(DirTable[i].hue, sat_reg, bri_reg);
      end
      send_hue(DirTable[i].hue, want, pick_gap(1'b0));
    end

    // Random phases, each under its own setting: extremes first, then
    // clamped, unrestricted and in-range register values
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: begin
          sat = cfg_t'(OneQ12); bri = cfg_t'(OneQ12);
        end
        1: begin
          sat = '0; bri = cfg_t'($urandom_range(OneQ12));
        end
        2: begin
          sat = '1; bri = '1;
        end
        3: begin
          sat = cfg_t'($urandom_range(OneQ12)); bri = '0;
        end
        4: begin
          sat = cfg_t'($urandom_range(8191, OneQ12 + 1));
          bri = cfg_t'($urandom_range(OneQ12));
        end
        5: begin
          sat = cfg_t'($urandom); bri = cfg_t'($urandom);
        end
        default: begin
          sat = cfg_t'($urandom_range(OneQ12)); bri = cfg_t'($urandom_range(OneQ12));
        end
      endcase
      drain_pipe();
      set_levels(sat, bri);
      // Some phases run at full rate on one or both sides
      in_steady  = (p == 2) || ($urandom_range(3) == 0);
      out_steady = (p == 3) || ($urandom_range(3) == 0);
      for (int n = 0; n < BeatsPerPhase; n++) begin
        hue_i_pick: begin
          hue_t hue;
          hue = pick_hue();
          send_hue(hue, hsv_duty(hue, sat_reg, bri_reg), pick_gap(in_steady));
        end
      end
    end

    in_steady  = 1'b0;
    out_steady = 1'b0;
    drain_pipe();

    $display("Run covered %0d hue beats and %0d output beats under %0d register settings.",
             beats_in, beats_out, settings);
    $display("Mismatches or stray beats: %0d", fail_cnt);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
